// ----- rtl/irft_pkg.sv -----
// Shared types and constants for the infrared remote frame transmitter.
// Holds register reset values, field widths and configuration register indexes.
// No dependencies.
package irft_pkg;

  // Default width of the space and gap timer
  localparam int IRFT_TIMER_WIDTH = 13;

  // Widths of configuration registers and of the config write port
  localparam int CARRIER_W = 8;
  localparam int TOGGLE_W  = 7;
  localparam int MARKS_W   = 5;
  localparam int SPACE_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Frame layout: four bytes, LSB first
  localparam int FRAME_BITS = 32;
  localparam int BITS_W     = 6;
  localparam logic [7:0] BYTE_INV_MASK = 8'hFF;

  // Register reset values
  localparam logic [CARRIER_W-1:0] CARRIER_HALF_RST = 8'd13;
  localparam logic [TOGGLE_W-1:0]  MARK_TOGGLES_RST = 7'd42;
  localparam logic [MARKS_W-1:0]   LEADER_MARKS_RST = 5'd16;
  localparam logic [SPACE_W-1:0]   LEADER_SPACE_RST = 13'd4500;
  localparam logic [SPACE_W-1:0]   SHORT_SPACE_RST  = 13'd550;
  localparam logic [SPACE_W-1:0]   LONG_SPACE_RST   = 13'd1675;
  localparam logic [SPACE_W-1:0]   TRAIL_GAP_RST    = 13'd4500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_HALF = 3'd0,
    REG_MARK_TOGGLES = 3'd1,
    REG_LEADER_MARKS = 3'd2,
    REG_LEADER_SPACE = 3'd3,
    REG_SHORT_SPACE  = 3'd4,
    REG_LONG_SPACE   = 3'd5,
    REG_TRAIL_GAP    = 3'd6
  } cfg_reg_t;

endpackage

// ----- rtl/ir_remote_frame_transmitter.sv -----
// Infrared remote frame transmitter (NEC-style framing), single module.
// Depends on irft_pkg for register defaults, widths and register indexes.
//
// Every input transfer is one 1 us timebase tick and yields exactly one output
// transfer describing that tick (emitter level, busy, frame done). The frame
// sequencer advances one tick per cycle unless stalled: an unstalled tick is taken
// when offered, so the block sustains one tick per clock. Results leave through an
// output register backed by a one-entry skid register, so input is stalled only
// when both hold untaken results. A start request while idle latches address
// and command and begins the frame on that tick; a start while busy is ignored.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; a new
// value is used the next time the matching counter is loaded.
module ir_remote_frame_transmitter
  import irft_pkg::*;
#(
  parameter int TIMER_WIDTH = IRFT_TIMER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  start_req,
  input  logic [7:0]            address,
  input  logic [7:0]            command_code,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  ir_level,
  output logic                  busy_res,
  output logic                  frame_done
);

  localparam int CW = (TIMER_WIDTH > SPACE_W) ? TIMER_WIDTH : SPACE_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = {TIMER_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK,
    PH_BIT_SPACE, PH_END_MARK, PH_GAP
  } phase_t;

  // Saturate a space value to the timer range, optionally forcing at least one.
  function automatic logic [TIMER_WIDTH-1:0] timer_clamp(input logic [SPACE_W-1:0] v,
                                                         input logic min_one);
    logic [CW-1:0] ext;
    logic [TIMER_WIDTH-1:0] r;
    ext = CW'(v);
    if (ext > CW'(TIMER_TOP)) r = TIMER_TOP;
    else                      r = TIMER_WIDTH'(ext);
    if (min_one && r == '0) r = TIMER_WIDTH'(1);
    return r;
  endfunction

  // Configuration registers
  logic [CARRIER_W-1:0] carrier_half_ticks;
  logic [TOGGLE_W-1:0]  mark_toggles;
  logic [MARKS_W-1:0]   leader_marks;
  logic [SPACE_W-1:0]   leader_space_ticks;
  logic [SPACE_W-1:0]   short_space_ticks;
  logic [SPACE_W-1:0]   long_space_ticks;
  logic [SPACE_W-1:0]   trailing_gap_ticks;

  // Sequencer state
  phase_t                  phase, phase_next;
  logic [FRAME_BITS-1:0]   frame_shift, frame_shift_next;
  logic [BITS_W-1:0]       bits_left, bits_left_next;
  logic [MARKS_W-1:0]      marks_left, marks_left_next;
  logic [TOGGLE_W-1:0]     toggles_left, toggles_left_next;
  logic [CARRIER_W-1:0]    carrier_count, carrier_count_next;
  logic [TIMER_WIDTH-1:0]  space_count, space_count_next;
  logic                    output_level, output_level_next;

  // Values after a possible frame start on this tick
  phase_t                  st_phase;
  logic [TOGGLE_W-1:0]     st_toggles;
  logic [CARRIER_W-1:0]    st_carrier;

  // Effective register values
  logic [CARRIER_W-1:0]    half_eff;
  logic [TOGGLE_W-1:0]     toggles_eff;
  logic [MARKS_W-1:0]      leader_eff;

  // One mark tick and one space tick, evaluated in parallel
  logic                    mt_edge;
  logic                    mt_level;
  logic [TOGGLE_W-1:0]     mt_toggles;
  logic [CARRIER_W-1:0]    mt_carrier;
  logic                    mt_end;
  logic [TIMER_WIDTH-1:0]  sp_count;
  logic                    sp_end;
  logic [MARKS_W-1:0]      marks_dec;
  logic [BITS_W-1:0]       bits_dec;
  logic [TIMER_WIDTH-1:0]  gap_len;

  logic                    lvl_res, busy_next, done_res;

  // Output register plus skid register
  logic                    skid_valid;
  logic                    skid_level, skid_busy, skid_done;
  logic                    in_fire, out_fire;

  assign half_eff    = (carrier_half_ticks == '0) ? CARRIER_W'(1) : carrier_half_ticks;
  assign toggles_eff = (mark_toggles < TOGGLE_W'(2)) ? TOGGLE_W'(2) : mark_toggles;
  assign leader_eff  = (leader_marks == '0) ? MARKS_W'(1) : leader_marks;
  assign gap_len     = timer_clamp(trailing_gap_ticks, 1'b0);

  // Tick evaluation: start handling, then one step of the current phase
  always_comb begin
    phase_next         = phase;
    frame_shift_next   = frame_shift;
    bits_left_next     = bits_left;
    marks_left_next    = marks_left;
    toggles_left_next  = toggles_left;
    carrier_count_next = carrier_count;
    space_count_next   = space_count;
    output_level_next  = output_level;
    st_phase           = phase;
    st_toggles         = toggles_left;
    st_carrier         = carrier_count;
    lvl_res            = 1'b0;
    done_res           = 1'b0;

    if (phase == PH_IDLE && start_req) begin
      frame_shift_next = {command_code ^ BYTE_INV_MASK, command_code,
                          address ^ BYTE_INV_MASK, address};
      bits_left_next   = BITS_W'(FRAME_BITS);
      marks_left_next  = leader_eff;
      st_phase         = PH_LEAD_MARK;
      st_toggles       = toggles_eff;
      st_carrier       = '0;
    end
    phase_next        = st_phase;
    toggles_left_next = st_toggles;
    carrier_count_next = st_carrier;
    busy_next         = (st_phase != PH_IDLE);

    // carrier step
    mt_edge    = (st_carrier == '0);
    mt_level   = mt_edge ? ~output_level : output_level;
    mt_toggles = (mt_edge && st_toggles != '0) ? st_toggles - TOGGLE_W'(1) : st_toggles;
    mt_carrier = (mt_edge ? half_eff : st_carrier) - CARRIER_W'(1);
    mt_end     = (mt_carrier == '0) && (mt_toggles == '0);

    // silent step
    sp_count = (space_count != '0) ? space_count - TIMER_WIDTH'(1) : space_count;
    sp_end   = (sp_count == '0);

    marks_dec = (marks_left_next != '0) ? marks_left_next - MARKS_W'(1) : marks_left_next;
    bits_dec  = (bits_left != '0) ? bits_left - BITS_W'(1) : bits_left;

    case (st_phase)
      PH_IDLE: begin
      end
      PH_LEAD_MARK, PH_BIT_MARK, PH_END_MARK: begin
        lvl_res            = mt_level;
        toggles_left_next  = mt_toggles;
        carrier_count_next = mt_carrier;
        output_level_next  = mt_end ? 1'b0 : mt_level;
        if (mt_end) begin
          if (st_phase == PH_LEAD_MARK) begin
            marks_left_next = marks_dec;
            if (marks_dec != '0) begin
              toggles_left_next  = toggles_eff;
              carrier_count_next = '0;
            end else begin
              phase_next       = PH_LEAD_SPACE;
              space_count_next = timer_clamp(leader_space_ticks, 1'b1);
            end
          end else if (st_phase == PH_BIT_MARK) begin
            phase_next       = PH_BIT_SPACE;
            space_count_next = frame_shift[0] ? timer_clamp(long_space_ticks, 1'b1)
                                              : timer_clamp(short_space_ticks, 1'b1);
          end else if (gap_len == '0) begin
            phase_next = PH_IDLE;
            done_res   = 1'b1;
          end else begin
            phase_next       = PH_GAP;
            space_count_next = gap_len;
          end
        end
      end
      PH_LEAD_SPACE: begin
        space_count_next = sp_count;
        if (sp_end) begin
          phase_next         = PH_BIT_MARK;
          toggles_left_next  = toggles_eff;
          carrier_count_next = '0;
        end
      end
      PH_BIT_SPACE: begin
        space_count_next = sp_count;
        if (sp_end) begin
          frame_shift_next   = frame_shift >> 1;
          bits_left_next     = bits_dec;
          phase_next         = (bits_dec != '0) ? PH_BIT_MARK : PH_END_MARK;
          toggles_left_next  = toggles_eff;
          carrier_count_next = '0;
        end
      end
      PH_GAP: begin
        space_count_next = sp_count;
        if (sp_end) begin
          phase_next = PH_IDLE;
          done_res   = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Handshake: input stalls only when the skid register is occupied
  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half_ticks <= CARRIER_HALF_RST;
      mark_toggles       <= MARK_TOGGLES_RST;
      leader_marks       <= LEADER_MARKS_RST;
      leader_space_ticks <= LEADER_SPACE_RST;
      short_space_ticks  <= SHORT_SPACE_RST;
      long_space_ticks   <= LONG_SPACE_RST;
      trailing_gap_ticks <= TRAIL_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CARRIER_HALF: carrier_half_ticks <= cfg_data[CARRIER_W-1:0];
        REG_MARK_TOGGLES: mark_toggles       <= cfg_data[TOGGLE_W-1:0];
        REG_LEADER_MARKS: leader_marks       <= cfg_data[MARKS_W-1:0];
        REG_LEADER_SPACE: leader_space_ticks <= cfg_data;
        REG_SHORT_SPACE:  short_space_ticks  <= cfg_data;
        REG_LONG_SPACE:   long_space_ticks   <= cfg_data;
        REG_TRAIL_GAP:    trailing_gap_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_shift   <= '0;
      bits_left     <= '0;
      marks_left    <= '0;
      toggles_left  <= '0;
      carrier_count <= '0;
      space_count   <= '0;
      output_level  <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      frame_shift   <= frame_shift_next;
      bits_left     <= bits_left_next;
      marks_left    <= marks_left_next;
      toggles_left  <= toggles_left_next;
      carrier_count <= carrier_count_next;
      space_count   <= space_count_next;
      output_level  <= output_level_next;
    end
  end

  // Result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        ir_level   <= skid_level;
        busy_res   <= skid_busy;
        frame_done <= skid_done;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        ir_level   <= lvl_res;
        busy_res   <= busy_next;
        frame_done <= done_res;
      end else begin
        skid_level <= lvl_res;
        skid_busy  <= busy_next;
        skid_done  <= done_res;
      end
    end
  end

endmodule
